// ===== rtl/core/fixed_slot_free_list_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-slot free list allocator
// Same-cycle and next-cycle implication checks on the rising clock edge,
// disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSFLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fsfla_pkg.sv =====
// ----------------------------------------------------------------------------
// fsfla_pkg
// Shared types and constants of the fixed-slot free list allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsfla_pkg;

  localparam int SLOT_W          = 12;
  localparam int LINK_W          = 13;
  localparam int CHUNK_CNT_W     = 4;
  localparam int SLOT_SPACE      = 4096;
  localparam int SlotsPerChunk   = 512;
  localparam int NUM_CHUNKS      = 8;
  localparam int FIT_CHUNKS      = SLOT_SPACE / SlotsPerChunk;
  localparam int MAX_CHUNKS      = (NUM_CHUNKS < FIT_CHUNKS) ? NUM_CHUNKS : FIT_CHUNKS;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOT_SPACE);

  typedef enum logic {
    MODE_ALLOC   = 1'b0,
    MODE_RELEASE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STAT_ALLOCATED    = 2'd0,
    STAT_RELEASED     = 2'd1,
    STAT_NULL_RELEASE = 2'd2,
    STAT_EXHAUSTED    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_CARVE
  } state_e;

  typedef struct packed {
    mode_e             mode;
    logic [SLOT_W-1:0] slot_index;
    logic              slot_present;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    status_e           status;
  } out_item_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ===== rtl/core/fixed_slot_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// Hands out and takes back fixed-size slots through a LIFO free list whose
// links live in a 4096-entry link memory. A release, a null release and an
// allocate that finds the pool exhausted leave the controller idle. An
// allocate from the list passes through the pop state, where the registered
// read of the link memory returns the new head. An allocate on an empty list
// carves a fresh chunk of SlotsPerChunk (512) slots: it grants the first
// slot at once, then the link memory write port fills in one link per cycle
// for the other slots, with input held off until the last link is written.
// Every result waits in an output register, and a new item is taken only
// while that register is empty or is emptied in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_slot_free_list_allocator_assert.svh"

module fixed_slot_free_list_allocator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  fsfla_pkg::in_item_t   in_item_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output fsfla_pkg::out_item_t  out_item_o,
  input  logic                  out_stall_i
);

  logic                         out_valid_q;
  fsfla_pkg::out_item_t         out_item_q;
  logic                         out_free;
  logic                         res_valid;
  fsfla_pkg::out_item_t         res;
  fsfla_pkg::mem_req_t          mem_req;
  logic [fsfla_pkg::LINK_W-1:0] mem_rd_data;

  assign out_free = !out_valid_q || !out_stall_i;

  fsfla_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_item_i     (in_item_i),
    .in_stall_o    (in_stall_o),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .mem_req_o     (mem_req),
    .mem_rd_data_i (mem_rd_data)
  );

  fsfla_link_ram u_link_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `FSFLA_ASSERT_NEXT(a_result_follows_item, in_valid_i && !in_stall_o, out_valid_o,
    "accepted item produced no result")
  `FSFLA_ASSERT_NEXT(a_alloc_holds_input,
    in_valid_i && !in_stall_o && in_item_i.mode == fsfla_pkg::MODE_ALLOC,
    in_stall_o || out_item_o.status == fsfla_pkg::STAT_EXHAUSTED,
    "allocate did not hold off input")
  `FSFLA_ASSERT_NOW(a_no_result_overwrite, out_valid_o && out_stall_i, !res_valid,
    "pending result overwritten")

endmodule

// ===== rtl/core/fsfla_link_ram.sv =====
// ----------------------------------------------------------------------------
// fsfla_link_ram
// Link memory: one next-slot entry per slot, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsfla_link_ram (
  input  logic                             clk_i,
  input  fsfla_pkg::mem_req_t              req_i,
  output logic [fsfla_pkg::LINK_W-1:0]     rd_data_o
);

  logic [fsfla_pkg::LINK_W-1:0] mem [fsfla_pkg::SLOT_SPACE];
  logic [fsfla_pkg::LINK_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/fsfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsfla_ctrl
// Free list control: head register, chunk counter, carve sweep and the
// accesses to the link memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsfla_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  fsfla_pkg::in_item_t          in_item_i,
  output logic                         in_stall_o,
  input  logic                         out_free_i,
  output logic                         res_valid_o,
  output fsfla_pkg::out_item_t         res_o,
  output fsfla_pkg::mem_req_t          mem_req_o,
  input  logic [fsfla_pkg::LINK_W-1:0] mem_rd_data_i
);

  fsfla_pkg::state_e                    state_q, state_d;
  logic [fsfla_pkg::LINK_W-1:0]         head_q, head_d;
  logic [fsfla_pkg::CHUNK_CNT_W-1:0]    chunks_q, chunks_d;
  logic [fsfla_pkg::SLOT_W-1:0]         cptr_q, cptr_d;
  logic [fsfla_pkg::SLOT_W-1:0]         clast_q, clast_d;

  logic                                 accept;
  logic                                 is_alloc;
  logic                                 head_valid;
  logic                                 carve_ok;
  logic [fsfla_pkg::LINK_W-1:0]         base;
  logic                                 carve_last;

  assign in_stall_o = (state_q != fsfla_pkg::ST_IDLE) || !out_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_alloc   = (in_item_i.mode == fsfla_pkg::MODE_ALLOC);
  assign head_valid = !head_q[fsfla_pkg::LINK_W-1];
  assign carve_ok   = chunks_q < fsfla_pkg::CHUNK_CNT_W'(fsfla_pkg::MAX_CHUNKS);
  assign base       = fsfla_pkg::LINK_W'(chunks_q)
                      * fsfla_pkg::LINK_W'(fsfla_pkg::SlotsPerChunk);
  assign carve_last = (cptr_q == clast_q);

  // next state and registers
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    chunks_d = chunks_q;
    cptr_d   = cptr_q;
    clast_d  = clast_q;
    case (state_q)
      fsfla_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_alloc) begin
            if (head_valid) begin
              state_d = fsfla_pkg::ST_POP;
            end else if (carve_ok) begin
              state_d  = fsfla_pkg::ST_CARVE;
              head_d   = base + fsfla_pkg::LINK_W'(1);
              chunks_d = chunks_q + fsfla_pkg::CHUNK_CNT_W'(1);
              cptr_d   = fsfla_pkg::SLOT_W'(base + fsfla_pkg::LINK_W'(1));
              clast_d  = fsfla_pkg::SLOT_W'(base
                         + fsfla_pkg::LINK_W'(fsfla_pkg::SlotsPerChunk - 1));
            end
          end else if (in_item_i.slot_present) begin
            head_d = {1'b0, in_item_i.slot_index};
          end
        end
      end
      fsfla_pkg::ST_POP: begin
        head_d  = mem_rd_data_i;
        state_d = fsfla_pkg::ST_IDLE;
      end
      fsfla_pkg::ST_CARVE: begin
        if (carve_last) begin
          state_d = fsfla_pkg::ST_IDLE;
        end else begin
          cptr_d = cptr_q + fsfla_pkg::SLOT_W'(1);
        end
      end
      default: begin
        state_d = fsfla_pkg::ST_IDLE;
      end
    endcase
  end

  // result and memory requests
  always_comb begin
    res_valid_o       = 1'b0;
    res_o             = '0;
    res_o.status      = fsfla_pkg::STAT_ALLOCATED;
    mem_req_o         = '0;
    case (state_q)
      fsfla_pkg::ST_IDLE: begin
        if (accept) begin
          res_valid_o = 1'b1;
          if (is_alloc) begin
            if (head_valid) begin
              res_o.granted_slot = head_q[fsfla_pkg::SLOT_W-1:0];
              mem_req_o.rd_en    = 1'b1;
              mem_req_o.rd_addr  = head_q[fsfla_pkg::SLOT_W-1:0];
            end else if (carve_ok) begin
              res_o.granted_slot = base[fsfla_pkg::SLOT_W-1:0];
            end else begin
              res_o.status = fsfla_pkg::STAT_EXHAUSTED;
            end
          end else if (in_item_i.slot_present) begin
            res_o.status      = fsfla_pkg::STAT_RELEASED;
            mem_req_o.wr_en   = 1'b1;
            mem_req_o.wr_addr = in_item_i.slot_index;
            mem_req_o.wr_data = head_q;
          end else begin
            res_o.status = fsfla_pkg::STAT_NULL_RELEASE;
          end
        end
      end
      fsfla_pkg::ST_CARVE: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = cptr_q;
        mem_req_o.wr_data = carve_last ? fsfla_pkg::NULL_LINK
                            : fsfla_pkg::LINK_W'(cptr_q) + fsfla_pkg::LINK_W'(1);
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fsfla_pkg::ST_IDLE;
      head_q   <= fsfla_pkg::NULL_LINK;
      chunks_q <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      chunks_q <= chunks_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cptr_q  <= cptr_d;
    clast_q <= clast_d;
  end

endmodule
